// File: rtl/running_statistics_accumulator_top_assert.svh
// Assertion macros shared by the running statistics accumulator.
`ifndef RUNNING_STATISTICS_ACCUMULATOR_TOP_ASSERT_SVH
`define RUNNING_STATISTICS_ACCUMULATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rsa_pkg.sv
package rsa_pkg;

  // Width of the three signed accumulators.
  localparam int ACC_WIDTH = 64;

  // Validity of the accumulators; a flag drops for good on overflow.
  typedef struct packed {
    logic total_valid;
    logic square_total_valid;
    logic running_product_valid;
  } acc_flags_t;

endpackage

// File: rtl/rsa_in_reg.sv
module rsa_in_reg import rsa_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_valid,
  output logic                    s_ready,
  input  logic [SAMPLE_WIDTH-1:0] s_sample,
  input  logic                    advance,
  output logic                    q_valid,
  output logic [SAMPLE_WIDTH-1:0] q_sample
);

  // The register takes a new sample when it is empty or is being drained.
  assign s_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      q_sample <= s_sample;
    end
  end

endmodule

// File: rtl/rsa_core.sv
`include "running_statistics_accumulator_top_assert.svh"

module rsa_core import rsa_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic        [SAMPLE_WIDTH-1:0] sample,
  output logic        [COUNT_WIDTH-1:0]  count,
  output logic signed [SAMPLE_WIDTH-1:0] min_val,
  output logic signed [SAMPLE_WIDTH-1:0] max_val,
  output logic        [ACC_WIDTH-1:0]    sum,
  output logic        [ACC_WIDTH-1:0]    sumsq,
  output logic        [ACC_WIDTH-1:0]    prod,
  output acc_flags_t                     flags
);

  localparam int FULL_WIDTH = ACC_WIDTH + SAMPLE_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0] v;
  logic        [ACC_WIDTH-1:0]    v_ext;
  logic        [SAMPLE_WIDTH-1:0] mag;
  logic        [2*SAMPLE_WIDTH-1:0] sq;
  logic        [ACC_WIDTH-1:0]    sq_ext;
  logic        [ACC_WIDTH-1:0]    sum_add;
  logic        [ACC_WIDTH-1:0]    sq_add;
  logic                           sum_ovf;
  logic                           sq_ovf;
  logic        [ACC_WIDTH-1:0]    prod_mag;
  logic                           prod_neg;
  logic        [FULL_WIDTH-1:0]   full;
  logic        [SAMPLE_WIDTH:0]   full_hi;
  logic        [ACC_WIDTH-2:0]    full_lo;
  logic                           prod_ovf;
  logic        [ACC_WIDTH-1:0]    prod_new;
  logic        [COUNT_WIDTH-1:0]  count_next;

  assign v     = $signed(sample);
  assign v_ext = ACC_WIDTH'(v);
  assign mag   = v[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-sample) : sample;

  assign count_next = (count == '1) ? count : count + 1'b1;

  // Running sum: signed overflow when both operands share a sign the result lacks.
  assign sum_add = sum + v_ext;
  assign sum_ovf = (sum[ACC_WIDTH-1] == v_ext[ACC_WIDTH-1]) &&
                   (sum_add[ACC_WIDTH-1] != sum[ACC_WIDTH-1]);

  // Sum of squares: the square never exceeds 2^30, so it is never negative.
  assign sq     = (2*SAMPLE_WIDTH)'(mag) * (2*SAMPLE_WIDTH)'(mag);
  assign sq_ext = ACC_WIDTH'(sq);
  assign sq_add = sumsq + sq_ext;
  assign sq_ovf = (sumsq[ACC_WIDTH-1] == sq_ext[ACC_WIDTH-1]) &&
                  (sq_add[ACC_WIDTH-1] != sumsq[ACC_WIDTH-1]);

  // Product as sign and magnitude. A negative result may reach 2^63,
  // a positive one only 2^63 - 1.
  assign prod_mag = prod[ACC_WIDTH-1] ? -prod : prod;
  assign prod_neg = prod[ACC_WIDTH-1] ^ v[SAMPLE_WIDTH-1];
  assign full     = FULL_WIDTH'(prod_mag) * FULL_WIDTH'(mag);
  assign full_hi  = full[FULL_WIDTH-1:ACC_WIDTH-1];
  assign full_lo  = full[ACC_WIDTH-2:0];
  assign prod_ovf = prod_neg ?
                    ((full_hi > (SAMPLE_WIDTH+1)'(1)) ||
                     ((full_hi == (SAMPLE_WIDTH+1)'(1)) && (full_lo != '0))) :
                    (full_hi != '0);
  assign prod_new = prod_neg ? -full[ACC_WIDTH-1:0] : full[ACC_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      min_val <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      max_val <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      sum     <= '0;
      sumsq   <= '0;
      prod    <= ACC_WIDTH'(1);
      flags   <= '1;
    end else if (advance) begin
      count <= count_next;
      if (v > max_val) begin
        max_val <= v;
      end
      if (v < min_val) begin
        min_val <= v;
      end
      if (flags.total_valid) begin
        if (sum_ovf) begin
          flags.total_valid <= 1'b0;
        end else begin
          sum <= sum_add;
        end
      end
      if (flags.square_total_valid) begin
        if (sq_ovf) begin
          flags.square_total_valid <= 1'b0;
        end else begin
          sumsq <= sq_add;
        end
      end
      if (flags.running_product_valid) begin
        if (prod_ovf) begin
          flags.running_product_valid <= 1'b0;
        end else begin
          prod <= prod_new;
        end
      end
    end
  end

  `RSA_ASSERT_NEXT(a_sum_frozen, clk, rst, !flags.total_valid,
    !flags.total_valid && $stable(sum), "running sum moved after overflow")
  `RSA_ASSERT_NEXT(a_prod_frozen, clk, rst, !flags.running_product_valid,
    !flags.running_product_valid && $stable(prod), "product moved after overflow")
  `RSA_ASSERT_NEXT(a_prod_zero, clk, rst, flags.running_product_valid && prod == '0,
    prod == '0, "zero product left zero")
  `RSA_ASSERT_SAME(a_min_max, clk, rst, count != '0,
    min_val <= max_val, "minimum above maximum after a sample")
  `RSA_ASSERT_NEXT(a_count_step, clk, rst, advance && count != '1,
    count == $past(count) + 1'b1, "count did not step by one")

endmodule

// File: rtl/running_statistics_accumulator_top.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  sample
// m_axis    out  m_axis_tvalid / m_axis_tready  count, min, max, sum, sum of squares,
//                                               product and the three valid flags
//
// The block takes one request per cycle while m_axis does not stall it, and
// returns one result per request. An accepted request loads the input
// register; once the output is free, the sample goes on through the update
// logic into the statistics registers, whose multiplier paths set the clock.
// Reset is synchronous and puts every statistic at its start value at once.
// While a result is stalled the input register still takes one more request.
module running_statistics_accumulator_top import rsa_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample in the low SAMPLE_WIDTH bits, zero padding above
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // item_count, minimum, maximum, total, total_valid, square_total,
  // square_total_valid, running_product, running_product_valid, zero padding
  output logic [((COUNT_WIDTH+2*SAMPLE_WIDTH+3*ACC_WIDTH+3+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OUT_BITS    = COUNT_WIDTH + 2*SAMPLE_WIDTH + 3*ACC_WIDTH + 3;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  logic                           q_valid;
  logic        [SAMPLE_WIDTH-1:0] q_sample;
  logic                           out_free;
  logic                           advance;
  logic        [COUNT_WIDTH-1:0]  count;
  logic signed [SAMPLE_WIDTH-1:0] min_val;
  logic signed [SAMPLE_WIDTH-1:0] max_val;
  logic        [ACC_WIDTH-1:0]    sum;
  logic        [ACC_WIDTH-1:0]    sumsq;
  logic        [ACC_WIDTH-1:0]    prod;
  acc_flags_t                     flags;

  // The statistics registers double as the result register, so they only
  // update when the previous result has been taken or was never there.
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign advance  = q_valid && out_free;

  rsa_in_reg #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_sample (q_sample)
  );

  rsa_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (q_sample),
    .count   (count),
    .min_val (min_val),
    .max_val (max_val),
    .sum     (sum),
    .sumsq   (sumsq),
    .prod    (prod),
    .flags   (flags)
  );

  // A result is pending from the update until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({flags.running_product_valid, prod,
                                      flags.square_total_valid, sumsq,
                                      flags.total_valid, sum,
                                      max_val, min_val, count});

endmodule
